// ===== sv/capability_link_table_macros.svh =====
// Assertion macros for the capability link table.
`ifndef CAPABILITY_LINK_TABLE_MACROS_SVH
`define CAPABILITY_LINK_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define CLT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CLT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLT_ASSERT(label, clk, rst_n, prop, msg)
`define CLT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== sv/clt_pkg.sv =====
// Types and constants shared by the capability link table modules.
package clt_pkg;

  localparam int NUM_SLOTS = 256;
  localparam int SLOT_W    = 8;
  localparam int CAP_W     = 64;
  localparam int PID_W     = 3;
  localparam int INDEX_W   = 5;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_MOVE   = 2'd3
  } clt_cmd_t;

  typedef struct packed {
    clt_cmd_t           cmd;
    logic [PID_W-1:0]   pid;
    logic [INDEX_W-1:0] index;
    logic [PID_W-1:0]   other_pid;
    logic [INDEX_W-1:0] other_index;
    logic [CAP_W-1:0]   cap_in;
  } in_word_t;

  typedef struct packed {
    logic [CAP_W-1:0]  cap_out;
    logic              is_empty;
    logic [SLOT_W-1:0] prev_slot;
    logic [SLOT_W-1:0] next_slot;
  } out_word_t;

  // controller -> datapath command group
  typedef struct packed {
    logic              load;     // take in a word, read slot a
    logic              link_rd;  // latch slot a, read successor of slot b
    logic              wr1;      // first write pass
    logic              wr2;      // second write pass
    logic              clr;      // clearing pass active
    logic [SLOT_W-1:0] clr_addr;
  } ctl_t;

endpackage

// ===== sv/clt_datapath.sv =====
// Slot memories, link update sequencing and result register.
module clt_datapath import clt_pkg::*; #(
  parameter int CAP_BITS = 64
) (
  input  logic      clk,
  input  ctl_t      ctl,
  input  in_word_t  in_data,
  output out_word_t out_data
);

  logic [CAP_BITS-1:0] cap_mem  [NUM_SLOTS];
  logic [SLOT_W-1:0]   prev_mem [NUM_SLOTS];
  logic [SLOT_W-1:0]   next_mem [NUM_SLOTS];

  logic [CAP_BITS-1:0] cap_rd_r;
  logic [SLOT_W-1:0]   prev_rd_r;
  logic [SLOT_W-1:0]   next_rd_r;

  clt_cmd_t            cmd_r;
  logic [SLOT_W-1:0]   a_r, b_r;
  logic [CAP_BITS-1:0] cap_in_r;
  logic [CAP_BITS-1:0] old_cap_r;
  logic [SLOT_W-1:0]   p_r, n_r;
  out_word_t           out_r;

  logic [SLOT_W-1:0]   a_in;
  logic [SLOT_W-1:0]   nb;
  logic [SLOT_W-1:0]   next_raddr;
  logic                next_re;

  logic                cap_we, prev_we, next_we;
  logic [SLOT_W-1:0]   cap_waddr, prev_waddr, next_waddr;
  logic [CAP_BITS-1:0] cap_wdata;
  logic [SLOT_W-1:0]   prev_wdata, next_wdata;

  assign a_in       = {in_data.pid, in_data.index};
  assign nb         = next_rd_r;  // successor of slot b, read during link_rd
  assign next_re    = ctl.load | ctl.link_rd;
  assign next_raddr = ctl.load ? a_in : b_r;

  always_comb begin
    cap_we     = 1'b0;
    prev_we    = 1'b0;
    next_we    = 1'b0;
    cap_waddr  = a_r;
    prev_waddr = a_r;
    next_waddr = a_r;
    cap_wdata  = '0;
    prev_wdata = '0;
    next_wdata = '0;
    if (ctl.clr) begin
      cap_we     = 1'b1;
      prev_we    = 1'b1;
      next_we    = 1'b1;
      cap_waddr  = ctl.clr_addr;
      prev_waddr = ctl.clr_addr;
      next_waddr = ctl.clr_addr;
    end else if (ctl.wr1) begin
      case (cmd_r)
        CMD_INSERT: begin
          cap_we     = 1'b1;
          cap_wdata  = cap_in_r;
          prev_we    = 1'b1;
          prev_wdata = b_r;
          next_we    = 1'b1;
          next_wdata = nb;
        end
        CMD_DELETE: begin
          cap_we     = 1'b1;
          next_we    = 1'b1;
          next_waddr = p_r;
          next_wdata = n_r;
          prev_we    = 1'b1;
          prev_waddr = n_r;
          prev_wdata = p_r;
        end
        CMD_MOVE: begin
          if (a_r != b_r) begin
            cap_we     = 1'b1;
            cap_waddr  = b_r;
            cap_wdata  = old_cap_r;
            prev_we    = 1'b1;
            prev_waddr = b_r;
            prev_wdata = p_r;
            next_we    = 1'b1;
            next_waddr = b_r;
            next_wdata = n_r;
          end
        end
        default: ;
      endcase
    end else if (ctl.wr2) begin
      case (cmd_r)
        CMD_INSERT: begin
          // self insert: a's successor is now a itself
          prev_we    = 1'b1;
          prev_waddr = (a_r == b_r) ? a_r : nb;
          prev_wdata = a_r;
          next_we    = 1'b1;
          next_waddr = b_r;
          next_wdata = a_r;
        end
        CMD_MOVE: begin
          if (a_r != b_r) begin
            // predecessor equal to destination: destination now points to itself
            prev_we    = 1'b1;
            prev_waddr = (p_r == b_r) ? b_r : n_r;
            prev_wdata = b_r;
            next_we    = 1'b1;
            next_waddr = p_r;
            next_wdata = b_r;
            cap_we     = 1'b1;
            cap_waddr  = a_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_mem[cap_waddr] <= cap_wdata;
    end
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (ctl.load) begin
      cap_rd_r  <= cap_mem[a_in];
      prev_rd_r <= prev_mem[a_in];
    end
    if (next_re) begin
      next_rd_r <= next_mem[next_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r    <= in_data.cmd;
      a_r      <= a_in;
      b_r      <= {in_data.other_pid, in_data.other_index};
      cap_in_r <= in_data.cap_in[CAP_BITS-1:0];
    end
    if (ctl.link_rd) begin
      old_cap_r          <= cap_rd_r;
      p_r                <= prev_rd_r;
      n_r                <= next_rd_r;
      out_r.cap_out      <= (cmd_r == CMD_READ || cmd_r == CMD_DELETE) ?
                            CAP_W'(cap_rd_r) : '0;
      out_r.is_empty     <= (cap_rd_r[3:0] == 4'd0);
      out_r.prev_slot    <= prev_rd_r;
      out_r.next_slot    <= next_rd_r;
    end
  end

  assign out_data = out_r;

endmodule

// ===== sv/clt_ctrl.sv =====
// Command sequencer: clearing pass, read phases, write phases, result strobe.
module clt_ctrl import clt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output logic out_valid,
  output ctl_t ctl
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LINK,
    S_WR1,
    S_WR2
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SLOT_W'(NUM_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        state_nxt     = S_WR1;
        out_valid_nxt = 1'b1;
      end
      S_WR1: state_nxt = S_WR2;
      S_WR2: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign ctl.load     = (state_r == S_IDLE) && start;
  assign ctl.link_rd  = (state_r == S_LINK);
  assign ctl.wr1      = (state_r == S_WR1);
  assign ctl.wr2      = (state_r == S_WR2);
  assign ctl.clr      = (state_r == S_CLEAR);
  assign ctl.clr_addr = clr_cnt_r;

`include "capability_link_table_macros.svh"

  `CLT_ASSERT(a_result_after_accept, clk, rst_n, (start && !busy) |=> ##1 out_valid, "no result two cycles after accept")
  `CLT_ASSERT(a_strobe_single, clk, rst_n, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `CLT_ASSERT(a_strobe_in_flight, clk, rst_n, out_valid |-> (busy && ctl.wr1), "result strobe outside a command")

endmodule

// ===== sv/capability_link_table.sv =====
// Top level of the capability link table.
// One command per start pulse, accepted when start is high and busy is low. Between one
// accept and the next possible accept, every command reads the addressed slot, then reads
// the successor of the other slot, then makes two write passes, since each of the
// three slot memories (word, predecessor, successor) has a single write port and an insert
// or move rewrites up to two links in each. The result word appears for exactly one cycle
// with out_valid high, in state S_WR1, which follows S_LINK after the accept; the receiver
// cannot stall it and must take it then. After reset, busy stays high while a clearing
// pass zeroes every one of the 256 slots, one slot per cycle.
module capability_link_table import clt_pkg::*; #(
  parameter int CAP_BITS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_data,
  output logic      out_valid,
  output out_word_t out_data
);

  ctl_t ctl;

  clt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  clt_datapath #(
    .CAP_BITS (CAP_BITS)
  ) u_datapath (
    .clk      (clk),
    .ctl      (ctl),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the capability link table.
`timescale 1ns / 1ps

module tb;
  import clt_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int POOL_SIZE   = 8;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_word_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  out_word_t out_data;

  capability_link_table u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // shadow copy of the slot table
  logic [CAP_W-1:0]  cap_mem  [NUM_SLOTS];
  logic [SLOT_W-1:0] prev_mem [NUM_SLOTS];
  logic [SLOT_W-1:0] next_mem [NUM_SLOTS];

  in_word_t  cmd_queue[$];
  out_word_t expected_words[$];
  logic [SLOT_W-1:0] slot_pool [POOL_SIZE];
  int idle_pct    = 22;
  int mismatches  = 0;
  int cycle_count = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic in_word_t make_word(clt_cmd_t c, logic [SLOT_W-1:0] a,
                                         logic [SLOT_W-1:0] b, logic [CAP_W-1:0] cap);
    in_word_t w;
    w.cmd         = c;
    w.pid         = a[SLOT_W-1:INDEX_W];
    w.index       = a[INDEX_W-1:0];
    w.other_pid   = b[SLOT_W-1:INDEX_W];
    w.other_index = b[INDEX_W-1:0];
    w.cap_in      = cap;
    return w;
  endfunction

  function automatic logic [CAP_W-1:0] rand_cap();
    logic [CAP_W-1:0] v;
    v = {$urandom, $urandom};
    // some words carry an empty type field with other bits set
    if ($urandom_range(4) == 0) v[3:0] = 4'd0;
    return v;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot();
    if ($urandom_range(99) < 70) return slot_pool[$urandom_range(POOL_SIZE-1)];
    return SLOT_W'($urandom_range(NUM_SLOTS-1));
  endfunction

  function automatic in_word_t rand_word();
    int r;
    clt_cmd_t c;
    logic [SLOT_W-1:0] a, b;
    r = $urandom_range(99);
    c = (r < 30) ? CMD_INSERT : (r < 55) ? CMD_READ : (r < 75) ? CMD_DELETE : CMD_MOVE;
    a = pick_slot();
    b = ($urandom_range(19) == 0) ? a : pick_slot();
    return make_word(c, a, b, rand_cap());
  endfunction

  // Applies one command to the shadow table and queues the expected result word.
  function automatic void apply_command(in_word_t w);
    logic [SLOT_W-1:0] a, b, p, n;
    logic [CAP_W-1:0] old;
    out_word_t r;
    a = {w.pid, w.index};
    b = {w.other_pid, w.other_index};
    old = cap_mem[a];
    r.cap_out   = '0;
    r.is_empty  = (old[3:0] == 4'd0);
    r.prev_slot = prev_mem[a];
    r.next_slot = next_mem[a];
    case (w.cmd)
      CMD_READ: begin
        r.cap_out = old;
      end
      CMD_INSERT: begin
        // sequential order matters when a slot is inserted after itself
        prev_mem[a]           = b;
        next_mem[a]           = next_mem[b];
        next_mem[prev_mem[a]] = a;
        prev_mem[next_mem[a]] = a;
        cap_mem[a]            = w.cap_in;
      end
      CMD_DELETE: begin
        r.cap_out   = old;
        cap_mem[a]  = '0;
        p           = prev_mem[a];
        n           = next_mem[a];
        next_mem[p] = n;
        p           = prev_mem[a];
        prev_mem[next_mem[a]] = p;
      end
      CMD_MOVE: begin
        if (a != b) begin
          cap_mem[b]            = cap_mem[a];
          cap_mem[a]            = '0;
          prev_mem[b]           = prev_mem[a];
          next_mem[b]           = next_mem[a];
          next_mem[prev_mem[b]] = b;
          prev_mem[next_mem[b]] = b;
        end
      end
      default: ;
    endcase
    expected_words.push_back(r);
  endfunction

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || start || expected_words.size() != 0) @(posedge clk);
  endtask

  // driver: holds a word until accepted, then maybe idles before the next one
  always @(posedge clk) begin : driver
    if (!rst_n) begin
      start <= 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        cap_mem[s]  = '0;
        prev_mem[s] = '0;
        next_mem[s] = '0;
      end
    end else begin
      if (start && !busy) apply_command(in_data);
      if (!(start && busy)) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start   <= 1'b1;
          in_data <= cmd_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result is checked against the oldest expectation
  always @(posedge clk) begin : monitor
    out_word_t want;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result word: cap %h empty %b prev %0d next %0d",
                   out_data.cap_out, out_data.is_empty, out_data.prev_slot,
                   out_data.next_slot);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (want.cap_out !== out_data.cap_out || want.is_empty !== out_data.is_empty ||
            want.prev_slot !== out_data.prev_slot ||
            want.next_slot !== out_data.next_slot) begin
          if (mismatches < 10)
            $display("mismatch (exp/act): cap %h/%h empty %b/%b prev %0d/%0d next %0d/%0d",
                     want.cap_out, out_data.cap_out, want.is_empty, out_data.is_empty,
                     want.prev_slot, out_data.prev_slot, want.next_slot,
                     out_data.next_slot);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int round;
    int k;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed words; slot numbers are {pid, index}
    cmd_queue.push_back(make_word(CMD_READ,   8'h00, 8'h00, '0));
    cmd_queue.push_back(make_word(CMD_READ,   8'hFF, 8'hFF, '1));
    cmd_queue.push_back(make_word(CMD_INSERT, 8'h01, 8'h01, 64'h0000_0000_0000_0001));
    cmd_queue.push_back(make_word(CMD_INSERT, 8'h02, 8'h01, '1));
    cmd_queue.push_back(make_word(CMD_INSERT, 8'hFF, 8'h02, 64'hFFFF_FFFF_FFFF_FFF0));
    cmd_queue.push_back(make_word(CMD_READ,   8'h02, 8'h00, '0));
    cmd_queue.push_back(make_word(CMD_READ,   8'hFF, 8'h00, '0));
    // insert over an occupied slot
    cmd_queue.push_back(make_word(CMD_INSERT, 8'h02, 8'hFF, 64'h5A5A_A5A5_0F0F_F0F3));
    cmd_queue.push_back(make_word(CMD_MOVE,   8'h02, 8'h02, '0));
    cmd_queue.push_back(make_word(CMD_MOVE,   8'h01, 8'hB1, '0));
    cmd_queue.push_back(make_word(CMD_READ,   8'h01, 8'h00, '0));
    cmd_queue.push_back(make_word(CMD_READ,   8'hB1, 8'h00, '0));
    cmd_queue.push_back(make_word(CMD_DELETE, 8'h02, 8'hFF, '1));
    cmd_queue.push_back(make_word(CMD_DELETE, 8'hB1, 8'h00, '0));
    cmd_queue.push_back(make_word(CMD_DELETE, 8'h00, 8'h00, '0));
    cmd_queue.push_back(make_word(CMD_MOVE,   8'h6A, 8'h94, '0));
    cmd_queue.push_back(make_word(CMD_INSERT, 8'hE0, 8'h00, 64'h8000_0000_0000_0001));
    cmd_queue.push_back(make_word(CMD_READ,   8'hE0, 8'hFF, '1));
    cmd_queue.push_back(make_word(CMD_MOVE,   8'hE0, 8'hFF, '0));
    cmd_queue.push_back(make_word(CMD_DELETE, 8'hFF, 8'h00, '0));
    cmd_queue.push_back(make_word(CMD_READ,   8'h00, 8'h00, '0));
    wait_drained();

    // each round builds a ring over a small slot pool, then works on it
    for (round = 0; round < 8; round++) begin
      idle_pct = (round == 3) ? 0 : 22;
      for (k = 0; k < POOL_SIZE; k++) slot_pool[k] = SLOT_W'($urandom_range(NUM_SLOTS-1));
      cmd_queue.push_back(make_word(CMD_INSERT, slot_pool[0], slot_pool[0], rand_cap()));
      for (k = 1; k < POOL_SIZE; k++)
        cmd_queue.push_back(make_word(CMD_INSERT, slot_pool[k], slot_pool[k-1], rand_cap()));
      for (k = 0; k < 108; k++) cmd_queue.push_back(rand_word());
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
